FILE: sv/assert_macros.svh
// assertion macros for the reply parser top level
// expects signals named clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define RRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define RRP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/rrp_pkg.sv
// shared types and constants of the reply parser
// no dependencies; used by every other file of the block but the assertion macros
package rrp_pkg;

	localparam int LEN_BITS_DEF   = 32;
	localparam int COUNT_BITS_DEF = 16;
	localparam int NUM_W          = 32;
	localparam int ELEM_W         = 16;
	localparam int BYTE_W         = 8;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		K_STRING  = 3'd0,
		K_ERROR   = 3'd1,
		K_INTEGER = 3'd2,
		K_BULK    = 3'd3,
		K_LIST    = 3'd4,
		K_UNKNOWN = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		EV_BYTE = 2'd0,
		EV_NULL = 2'd1,
		EV_VEND = 2'd2,
		EV_REND = 2'd3
	} event_t;

	// up to three events caused by one input byte, in order ev0, ev1, ev2
	typedef struct packed {
		logic [1:0]        n;
		event_t            ev0;
		event_t            ev1;
		event_t            ev2;
		logic [BYTE_W-1:0] data;
		logic [ELEM_W-1:0] elem;
		kind_t             kind;
	} bundle_t;

endpackage

FILE: sv/rrp_in_if.sv
// byte channel into the reply parser
// depends on rrp_pkg for the byte width
interface rrp_in_if import rrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              final_byte;

	modport source (output valid, output rx_byte, output final_byte, input ready);
	modport sink (input valid, input rx_byte, input final_byte, output ready);
endinterface

FILE: sv/rrp_out_if.sv
// event channel out of the reply parser
// depends on rrp_pkg for field widths
interface rrp_out_if import rrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        reply_kind;
	logic [1:0]        event_kind;
	logic [BYTE_W-1:0] value_byte;
	logic [ELEM_W-1:0] element_number;
	logic              run_last;

	modport source (output valid, output reply_kind, output event_kind, output value_byte,
		output element_number, output run_last, input ready);
	modport sink (input valid, input reply_kind, input event_kind, input value_byte,
		input element_number, input run_last, output ready);
endinterface

FILE: sv/resp_reply_parser.sv
// top level of the reply parser: front, bundle queue and back
// depends on rrp_pkg, rrp_in_if, rrp_out_if, rrp_front, rrp_queue, rrp_back, assert_macros.svh
//
//  port     dir   carries
//  reply    sink  rx_byte, final_byte: one reply byte per transaction
//  result   src   reply_kind, event_kind, value_byte, element_number, run_last
//
// one byte per cycle while each byte gives at most one event and result is ready;
// the number line costs a times-ten add and saturate in the front each cycle
// a byte giving k events takes k result transactions; the queue of four
// bundles takes up the difference and fills under long bursts or result stalls
// first event of a byte reaches result through the queue register, behind any queued bundles
// asynchronous reset clears all parse state at once, no clearing pass
// either side may stall freely; the queue decouples them
module resp_reply_parser import rrp_pkg::*; #(
	parameter int LEN_BITS   = LEN_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rrp_in_if.sink    reply,
	rrp_out_if.source result
);
	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

	bundle_t          front_bundle;
	bundle_t          q_head;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	logic [CNT_W-1:0] q_count;
	logic [CNT_W-1:0] q_count_exp;
	logic             final_take;
	logic             closes_reply;

	rrp_front #(
		.LEN_BITS   (LEN_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.reply  (reply),
		.q_full (q_full),
		.push   (push),
		.bundle (front_bundle)
	);

	rrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_bundle),
		.pop    (pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty),
		.count  (q_count)
	);

	rrp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (pop),
		.result (result)
	);

	// checker helpers
	assign q_count_exp  = q_count + CNT_W'(push) - CNT_W'(pop);
	assign final_take   = reply.valid && reply.ready && reply.final_byte;
	assign closes_reply = (front_bundle.n == 2'd1 && front_bundle.ev0 == EV_REND)
		|| (front_bundle.n == 2'd2 && front_bundle.ev1 == EV_REND)
		|| (front_bundle.n == 2'd3 && front_bundle.ev2 == EV_REND);

	`RRP_NEVER(a_push_when_full, push && q_full, "bundle pushed into a full queue")
	`RRP_NEVER(a_pop_when_empty, pop && q_empty, "bundle popped from an empty queue")
	`RRP_ASSERT(a_count_track, 1'b1 |=> (q_count == $past(q_count_exp)), "queue count off")
	`RRP_ASSERT(a_final_closes, final_take |-> (push && closes_reply), "final without reply end")
endmodule

FILE: sv/rrp_queue.sv
// short register queue of event bundles between parser front and back
// depends on rrp_pkg for bundle_t and the queue depth
module rrp_queue import rrp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bundle_t                    wdata,
	input  logic                       pop,
	output bundle_t                    head,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	bundle_t           entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: sv/rrp_front.sv
// parser front: accepts reply bytes, runs the parse state and packs the events
// of each byte into one bundle; depends on rrp_pkg and rrp_in_if
module rrp_front import rrp_pkg::*; #(
	parameter int LEN_BITS   = LEN_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rrp_in_if.sink        reply,
	input  logic          q_full,
	output logic          push,
	output bundle_t       bundle
);
	typedef enum logic [10:0] {
		PH_TYPE      = 11'b000_0000_0001,
		PH_LINE      = 11'b000_0000_0010,
		PH_LEN_NUM   = 11'b000_0000_0100,
		PH_LEN_LF    = 11'b000_0000_1000,
		PH_CNT_NUM   = 11'b000_0001_0000,
		PH_CNT_LF    = 11'b000_0010_0000,
		PH_DATA      = 11'b000_0100_0000,
		PH_DATA_CR   = 11'b000_1000_0000,
		PH_DATA_LF   = 11'b001_0000_0000,
		PH_ELEM_SKIP = 11'b010_0000_0000,
		PH_TAIL      = 11'b100_0000_0000
	} phase_t;

	localparam logic [NUM_W-1:0] LEN_CAP = NUM_W'((64'd1 << LEN_BITS) - 64'd1);
	localparam logic [NUM_W-1:0] CNT_CAP = NUM_W'((64'd1 << COUNT_BITS) - 64'd1);

	phase_t                phase_q, nx_phase;
	kind_t                 kind_q, nx_kind;
	logic [NUM_W-1:0]      acc_q, nx_acc;
	logic                  neg_q, nx_neg;
	logic                  inv_q, nx_inv;
	logic                  begun_q, nx_begun;
	logic [LEN_BITS-1:0]   left_q, nx_left;
	logic [COUNT_BITS-1:0] elems_q, nx_elems;
	logic [ELEM_W-1:0]     elem_cnt_q, nx_elem_cnt;
	logic [BYTE_W-1:0]     held0_q, nx_held0;
	logic [BYTE_W-1:0]     held1_q, nx_held1;
	logic [1:0]            held_cnt_q, nx_held_cnt;

	logic                  take;
	logic [BYTE_W-1:0]     c;
	logic                  is_digit, is_sign;
	logic [NUM_W+3:0]      mul;
	logic [NUM_W-1:0]      acc_dig;
	logic                  num_neg;
	logic [NUM_W-1:0]      mag_all, mag_len32, mag_cnt32;
	logic [LEN_BITS-1:0]   mag_len, left_dec;
	logic [COUNT_BITS-1:0] mag_cnt, elems_dec;
	logic                  list_kind;
	logic                  ev_a, ev_b;
	event_t                ev_a_kind;
	logic [BYTE_W-1:0]     ev_data;

	assign c           = reply.rx_byte;
	assign reply.ready = !q_full;
	assign take        = reply.valid && reply.ready;

	// number text helpers: times ten plus digit, saturating at 32 bits
	assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
	assign mul       = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {{NUM_W{1'b0}}, c[3:0]};
	assign acc_dig   = (|mul[NUM_W+3:NUM_W]) ? '1 : mul[NUM_W-1:0];
	assign num_neg   = !inv_q && neg_q && (acc_q != '0);
	assign mag_all   = inv_q ? '0 : acc_q;
	assign mag_len32 = (mag_all > LEN_CAP) ? LEN_CAP : mag_all;
	assign mag_cnt32 = (mag_all > CNT_CAP) ? CNT_CAP : mag_all;
	assign mag_len   = mag_len32[LEN_BITS-1:0];
	assign mag_cnt   = mag_cnt32[COUNT_BITS-1:0];
	assign left_dec  = (left_q != '0) ? left_q - 1'b1 : '0;
	assign elems_dec = (elems_q != '0) ? elems_q - 1'b1 : '0;
	assign list_kind = (kind_q == K_LIST);

	always_comb begin
		nx_phase    = phase_q;
		nx_kind     = kind_q;
		nx_acc      = acc_q;
		nx_neg      = neg_q;
		nx_inv      = inv_q;
		nx_begun    = begun_q;
		nx_left     = left_q;
		nx_elems    = elems_q;
		nx_elem_cnt = elem_cnt_q;
		nx_held0    = held0_q;
		nx_held1    = held1_q;
		nx_held_cnt = held_cnt_q;
		ev_a        = 1'b0;
		ev_a_kind   = EV_BYTE;
		ev_b        = 1'b0;
		ev_data     = '0;

		unique case (phase_q)
			PH_TYPE: begin
				case (c)
					CH_PLUS: begin
						nx_kind  = K_STRING;
						nx_phase = PH_LINE;
					end
					CH_MINUS: begin
						nx_kind  = K_ERROR;
						nx_phase = PH_LINE;
					end
					CH_COLON: begin
						nx_kind  = K_INTEGER;
						nx_phase = PH_LINE;
					end
					CH_DOLLAR: begin
						nx_kind  = K_BULK;
						nx_acc   = '0;
						nx_neg   = 1'b0;
						nx_inv   = 1'b0;
						nx_begun = 1'b0;
						nx_phase = PH_LEN_NUM;
					end
					CH_STAR: begin
						nx_kind  = K_LIST;
						nx_acc   = '0;
						nx_neg   = 1'b0;
						nx_inv   = 1'b0;
						nx_begun = 1'b0;
						nx_phase = PH_CNT_NUM;
					end
					default: begin
						nx_kind  = K_UNKNOWN;
						nx_phase = PH_TAIL;
					end
				endcase
			end
			PH_LINE: begin
				// two bytes are held back so the closing cr lf never leaves
				if (held_cnt_q[1]) begin
					ev_a     = 1'b1;
					ev_data  = held0_q;
					nx_held0 = held1_q;
					nx_held1 = c;
				end else begin
					if (held_cnt_q == 2'd0) begin
						nx_held0 = c;
					end else begin
						nx_held1 = c;
					end
					nx_held_cnt = held_cnt_q + 1'b1;
				end
			end
			PH_LEN_NUM, PH_CNT_NUM: begin
				if (c == CH_CR) begin
					nx_phase = (phase_q == PH_LEN_NUM) ? PH_LEN_LF : PH_CNT_LF;
				end else begin
					if (is_digit) begin
						nx_acc = acc_dig;
					end else if (!begun_q && is_sign) begin
						nx_neg = (c == CH_MINUS);
					end else begin
						nx_inv = 1'b1;
					end
					nx_begun = 1'b1;
				end
			end
			PH_LEN_LF: begin
				if (c == CH_LF) begin
					if (num_neg) begin
						ev_a      = 1'b1;
						ev_a_kind = EV_NULL;
						ev_b      = 1'b1;
						if (list_kind) begin
							nx_elem_cnt = elem_cnt_q + 1'b1;
							nx_elems    = elems_dec;
							nx_phase    = (elems_dec != '0) ? PH_ELEM_SKIP : PH_TAIL;
						end else begin
							nx_phase = PH_TAIL;
						end
					end else begin
						nx_left = mag_len;
						if (mag_len == '0) begin
							ev_b     = 1'b1;
							nx_phase = list_kind ? PH_DATA_CR : PH_TAIL;
						end else begin
							nx_phase = PH_DATA;
						end
					end
				end else begin
					// a broken line end spoils the number
					nx_inv   = 1'b1;
					nx_begun = 1'b1;
					if (c != CH_CR) begin
						if (is_digit) begin
							nx_acc = acc_dig;
						end
						nx_phase = PH_LEN_NUM;
					end
				end
			end
			PH_CNT_LF: begin
				if (c == CH_LF) begin
					nx_elems    = num_neg ? '0 : mag_cnt;
					nx_elem_cnt = '0;
					nx_phase    = (!num_neg && (mag_cnt != '0)) ? PH_ELEM_SKIP : PH_TAIL;
				end else begin
					nx_inv   = 1'b1;
					nx_begun = 1'b1;
					if (c != CH_CR) begin
						if (is_digit) begin
							nx_acc = acc_dig;
						end
						nx_phase = PH_CNT_NUM;
					end
				end
			end
			PH_DATA: begin
				ev_a    = 1'b1;
				ev_data = c;
				nx_left = left_dec;
				if (left_dec == '0) begin
					ev_b     = 1'b1;
					nx_phase = list_kind ? PH_DATA_CR : PH_TAIL;
				end
			end
			PH_DATA_CR: begin
				nx_phase = PH_DATA_LF;
			end
			PH_DATA_LF: begin
				nx_elem_cnt = elem_cnt_q + 1'b1;
				nx_elems    = elems_dec;
				nx_phase    = (elems_dec != '0) ? PH_ELEM_SKIP : PH_TAIL;
			end
			PH_ELEM_SKIP: begin
				nx_acc   = '0;
				nx_neg   = 1'b0;
				nx_inv   = 1'b0;
				nx_begun = 1'b0;
				nx_phase = PH_LEN_NUM;
			end
			PH_TAIL: begin
				nx_phase = PH_TAIL;
			end
			default: begin
				nx_phase = PH_TAIL;
			end
		endcase
	end

	// event packing: [byte or null] [value end] [reply end], gaps squeezed out
	logic ev_b_all;
	logic ev_c;

	assign ev_c     = reply.final_byte;
	assign ev_b_all = ev_b || (ev_c && ((nx_phase == PH_LINE) || (nx_phase == PH_DATA)));

	always_comb begin
		bundle.n    = 2'({1'b0, ev_a} + {1'b0, ev_b_all} + {1'b0, ev_c});
		bundle.ev0  = ev_a ? ev_a_kind : (ev_b_all ? EV_VEND : EV_REND);
		bundle.ev1  = (ev_a && ev_b_all) ? EV_VEND : EV_REND;
		bundle.ev2  = EV_REND;
		bundle.data = ev_data;
		bundle.elem = elem_cnt_q;
		bundle.kind = nx_kind;
	end

	assign push = take && (bundle.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			kind_q     <= K_STRING;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			inv_q      <= 1'b0;
			begun_q    <= 1'b0;
			left_q     <= '0;
			elems_q    <= '0;
			elem_cnt_q <= '0;
			held0_q    <= '0;
			held1_q    <= '0;
			held_cnt_q <= '0;
		end else if (take) begin
			if (reply.final_byte) begin
				phase_q    <= PH_TYPE;
				kind_q     <= K_STRING;
				acc_q      <= '0;
				neg_q      <= 1'b0;
				inv_q      <= 1'b0;
				begun_q    <= 1'b0;
				left_q     <= '0;
				elems_q    <= '0;
				elem_cnt_q <= '0;
				held0_q    <= '0;
				held1_q    <= '0;
				held_cnt_q <= '0;
			end else begin
				phase_q    <= nx_phase;
				kind_q     <= nx_kind;
				acc_q      <= nx_acc;
				neg_q      <= nx_neg;
				inv_q      <= nx_inv;
				begun_q    <= nx_begun;
				left_q     <= nx_left;
				elems_q    <= nx_elems;
				elem_cnt_q <= nx_elem_cnt;
				held0_q    <= nx_held0;
				held1_q    <= nx_held1;
				held_cnt_q <= nx_held_cnt;
			end
		end
	end
endmodule

FILE: sv/rrp_back.sv
// parser back: walks the events of the bundle at the queue head, one a cycle while result is ready
// depends on rrp_pkg and rrp_out_if
module rrp_back import rrp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bundle_t  head,
	input  logic     empty,
	output logic     pop,
	rrp_out_if.source result
);
	logic [1:0] idx_q;
	event_t     cur_ev;
	logic       last_ev;
	logic       fire;

	always_comb begin
		case (idx_q)
			2'd0:    cur_ev = head.ev0;
			2'd1:    cur_ev = head.ev1;
			default: cur_ev = head.ev2;
		endcase
	end

	assign last_ev = (idx_q == (head.n - 2'd1));
	assign fire    = result.valid && result.ready;
	assign pop     = fire && last_ev;

	assign result.valid          = !empty;
	assign result.reply_kind     = head.kind;
	assign result.event_kind     = cur_ev;
	assign result.value_byte     = (cur_ev == EV_BYTE) ? head.data : '0;
	assign result.element_number = ((head.kind == K_LIST) && (cur_ev != EV_REND)) ? head.elem : '0;
	assign result.run_last       = last_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= last_ev ? 2'd0 : idx_q + 1'b1;
		end
	end
endmodule

FILE: tb/resp_reply_parser_tb.sv
// testbench for resp_reply_parser: directed and random replies, checked event by event
// depends on rrp_pkg, rrp_in_if, rrp_out_if and the resp_reply_parser rtl
module resp_reply_parser_tb import rrp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_PRINTS   = 40;
	localparam int LEN_BITS     = LEN_BITS_DEF;
	localparam int COUNT_BITS   = COUNT_BITS_DEF;

	typedef enum logic [3:0] {
		AT_TYPE, AT_LINE, AT_LEN_DIGITS, AT_LEN_LF, AT_COUNT_DIGITS, AT_COUNT_LF,
		AT_DATA, AT_DATA_CR, AT_DATA_LF, AT_ELEM_SKIP, AT_TAIL
	} parse_phase_t;

	typedef enum logic [1:0] {SINK_FREE, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

	typedef struct packed {
		kind_t             kind;
		event_t            ev;
		logic [BYTE_W-1:0] data;
		logic [ELEM_W-1:0] elem;
		logic              last;
	} parser_event_t;

	logic clk = 1'b0;
	logic arst_n;

	rrp_in_if  reply();
	rrp_out_if result();

	resp_reply_parser #(
		.LEN_BITS   (LEN_BITS),
		.COUNT_BITS (COUNT_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.reply  (reply),
		.result (result)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predicted parser state
	parse_phase_t      phase;
	kind_t             cur_kind;
	logic [31:0]       num_acc;
	logic              num_neg;
	logic              num_bad;
	logic              num_begun;
	logic [31:0]       bytes_left;
	logic [31:0]       elems_left;
	logic [ELEM_W-1:0] elem_ctr;
	logic [BYTE_W-1:0] held [2];
	logic [1:0]        held_cnt;

	parser_event_t step_buf [3];
	int            step_n;
	parser_event_t pending_events [$];
	parser_event_t want;

	logic [BYTE_W-1:0] reply_text [$];

	int         cycle_count = 0;
	int         errors = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	int         gap_max = 4;
	sink_mode_t sink_mode = SINK_PATTERN;
	logic [7:0] sink_pattern = 8'b1011_0111;
	int         hold_wanted = 0;
	int         hold_served = 0;
	int         hold_left = 0;

	task automatic report_mismatch(string what);
		if (errors < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		errors++;
	endtask

	function automatic void note_event(event_t ev, logic [BYTE_W-1:0] b, bit in_elem);
		if (step_n < 3) begin
			step_buf[step_n].kind = cur_kind;
			step_buf[step_n].ev   = ev;
			step_buf[step_n].data = (ev == EV_BYTE) ? b : '0;
			step_buf[step_n].elem = (in_elem && cur_kind == K_LIST) ? elem_ctr : '0;
			step_buf[step_n].last = 1'b0;
			step_n++;
		end
	endfunction

	function automatic void clear_parser();
		phase      = AT_TYPE;
		cur_kind   = K_STRING;
		num_acc    = '0;
		num_neg    = 1'b0;
		num_bad    = 1'b0;
		num_begun  = 1'b0;
		bytes_left = '0;
		elems_left = '0;
		elem_ctr   = '0;
		held[0]    = '0;
		held[1]    = '0;
		held_cnt   = '0;
	endfunction

	function automatic void number_restart();
		num_acc   = '0;
		num_neg   = 1'b0;
		num_bad   = 1'b0;
		num_begun = 1'b0;
	endfunction

	function automatic void take_number_char(logic [BYTE_W-1:0] c);
		logic [35:0] wide;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			wide = {4'd0, num_acc} * 36'd10 + {28'd0, c - CH_ZERO};
			num_acc = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
		end else if (!num_begun && (c == CH_MINUS || c == CH_PLUS)) begin
			num_neg = (c == CH_MINUS);
		end else begin
			num_bad = 1'b1;
		end
		num_begun = 1'b1;
	endfunction

	// true once CR LF closes the number line
	function automatic bit feed_number(logic [BYTE_W-1:0] c, parse_phase_t digits_ph,
		parse_phase_t lf_ph);
		if (phase == digits_ph) begin
			if (c == CH_CR)
				phase = lf_ph;
			else
				take_number_char(c);
			return 1'b0;
		end
		if (c == CH_LF)
			return 1'b1;
		// CR not followed by LF spoils the number
		num_bad   = 1'b1;
		num_begun = 1'b1;
		if (c != CH_CR) begin
			take_number_char(c);
			phase = digits_ph;
		end
		return 1'b0;
	endfunction

	function automatic bit number_negative();
		return !num_bad && num_neg && num_acc != 0;
	endfunction

	function automatic logic [31:0] number_capped(int bits);
		logic [63:0] m;
		logic [63:0] cap;
		m   = num_bad ? 64'd0 : {32'd0, num_acc};
		cap = (64'd1 << bits) - 64'd1;
		return (m > cap) ? cap[31:0] : m[31:0];
	endfunction

	function automatic void element_finished();
		elem_ctr   = elem_ctr + 1'b1;
		elems_left = (elems_left != 0) ? elems_left - 1 : 0;
		phase      = (elems_left != 0) ? AT_ELEM_SKIP : AT_TAIL;
	endfunction

	function automatic void value_finished();
		note_event(EV_VEND, '0, 1'b1);
		phase = (cur_kind == K_LIST) ? AT_DATA_CR : AT_TAIL;
	endfunction

	function automatic void length_finished();
		if (number_negative()) begin
			note_event(EV_NULL, '0, 1'b1);
			note_event(EV_VEND, '0, 1'b1);
			if (cur_kind == K_LIST)
				element_finished();
			else
				phase = AT_TAIL;
		end else begin
			bytes_left = number_capped(LEN_BITS);
			if (bytes_left == 0)
				value_finished();
			else
				phase = AT_DATA;
		end
	endfunction

	function automatic void predict_parser_events(logic [BYTE_W-1:0] c, logic fin);
		step_n = 0;
		case (phase)
			AT_TYPE: begin
				case (c)
					CH_PLUS: begin
						cur_kind = K_STRING;
						phase = AT_LINE;
					end
					CH_MINUS: begin
						cur_kind = K_ERROR;
						phase = AT_LINE;
					end
					CH_COLON: begin
						cur_kind = K_INTEGER;
						phase = AT_LINE;
					end
					CH_DOLLAR: begin
						cur_kind = K_BULK;
						number_restart();
						phase = AT_LEN_DIGITS;
					end
					CH_STAR: begin
						cur_kind = K_LIST;
						number_restart();
						phase = AT_COUNT_DIGITS;
					end
					default: begin
						cur_kind = K_UNKNOWN;
						phase = AT_TAIL;
					end
				endcase
			end
			AT_LINE: begin
				// two bytes held back so the closing CR LF never shows
				if (held_cnt >= 2) begin
					note_event(EV_BYTE, held[0], 1'b0);
					held[0] = held[1];
					held[1] = c;
				end else begin
					held[held_cnt] = c;
					held_cnt++;
				end
			end
			AT_LEN_DIGITS, AT_LEN_LF: begin
				if (feed_number(c, AT_LEN_DIGITS, AT_LEN_LF))
					length_finished();
			end
			AT_COUNT_DIGITS, AT_COUNT_LF: begin
				if (feed_number(c, AT_COUNT_DIGITS, AT_COUNT_LF)) begin
					elems_left = number_negative() ? 32'd0 : number_capped(COUNT_BITS);
					elem_ctr   = '0;
					phase      = (elems_left != 0) ? AT_ELEM_SKIP : AT_TAIL;
				end
			end
			AT_DATA: begin
				note_event(EV_BYTE, c, 1'b1);
				if (bytes_left != 0)
					bytes_left--;
				if (bytes_left == 0)
					value_finished();
			end
			AT_DATA_CR: phase = AT_DATA_LF;
			AT_DATA_LF: element_finished();
			AT_ELEM_SKIP: begin
				number_restart();
				phase = AT_LEN_DIGITS;
			end
			default: ;
		endcase
		if (fin) begin
			if (phase == AT_LINE || phase == AT_DATA)
				note_event(EV_VEND, '0, 1'b1);
			note_event(EV_REND, '0, 1'b0);
			clear_parser();
		end
		if (step_n > 0)
			step_buf[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			pending_events.push_back(step_buf[i]);
	endfunction

	// entered and left on a rising edge
	task automatic send_byte(logic [BYTE_W-1:0] c, logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 12);
			repeat (gap) begin
				reply.valid <= 1'b0;
				@(posedge clk);
			end
		end
		burst_left--;
		predict_parser_events(c, fin);
		reply.valid      <= 1'b1;
		reply.rx_byte    <= c;
		reply.final_byte <= fin;
		@(posedge clk);
		while (reply.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic void add_byte(logic [BYTE_W-1:0] b);
		reply_text.push_back(b);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			reply_text.push_back(s[i]);
	endfunction

	function automatic void add_crlf();
		reply_text.push_back(CH_CR);
		reply_text.push_back(CH_LF);
	endfunction

	function automatic void add_random_bytes(int n);
		repeat (n)
			reply_text.push_back(BYTE_W'($urandom_range(0, 255)));
	endfunction

	// writes a length line; gives the data bytes that should follow, -1 for null
	function automatic int add_length(int max_len);
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = $urandom_range(0, max_len);
		if (r < 62) begin
			add_text($sformatf("%0d", n));
		end else if (r < 71) begin
			add_text("-1");
			n = -1;
		end else if (r < 74) begin
			add_text($sformatf("-%0d", $urandom_range(2, 100000)));
			n = -1;
		end else if (r < 77) begin
			add_text($sformatf("+%0d", n));
		end else if (r < 80) begin
			add_text($sformatf("000%0d", n));
		end else if (r < 83) begin
			add_text("-0");
			n = 0;
		end else if (r < 86) begin
			n = 0;
		end else if (r < 90) begin
			// huge or saturating length, so the data runs to the final byte
			add_text(($urandom_range(0, 1) == 0) ? "4294967295" : "98765432109876");
			n = $urandom_range(0, 3);
		end else if (r < 95) begin
			add_text($sformatf("%0d-%0d", n, n));
			n = 0;
		end else begin
			add_text($sformatf("%0d", n));
			add_byte(CH_CR);
			add_text($sformatf("%0d", n));
			n = 0;
		end
		add_crlf();
		return n;
	endfunction

	function automatic void build_line_reply();
		case ($urandom_range(0, 2))
			0: add_byte(CH_PLUS);
			1: add_byte(CH_MINUS);
			default: add_byte(CH_COLON);
		endcase
		add_random_bytes($urandom_range(0, 8));
		add_crlf();
	endfunction

	function automatic void build_bulk_reply();
		int n;
		add_byte(CH_DOLLAR);
		n = add_length(8);
		if (n >= 0) begin
			add_random_bytes(n);
			add_crlf();
		end
		if ($urandom_range(0, 9) == 0)
			add_random_bytes($urandom_range(1, 4));
	endfunction

	function automatic void build_list_reply();
		int r;
		int elems;
		int n;
		add_byte(CH_STAR);
		r = $urandom_range(0, 99);
		elems = $urandom_range(0, 4);
		if (r < 70) begin
			add_text($sformatf("%0d", elems));
		end else if (r < 78) begin
			add_text("-1");
			elems = 0;
		end else if (r < 84) begin
			add_text("65536");
			elems = 3;
		end else if (r < 88) begin
			add_text("4294967296");
			elems = 2;
		end else if (r < 92) begin
			elems = 0;
		end else begin
			add_text($sformatf("%0d+", elems));
			elems = $urandom_range(0, 1);
		end
		add_crlf();
		for (int e = 0; e < elems; e++) begin
			// the element type byte is skipped, whatever it is
			if ($urandom_range(0, 3) == 0)
				add_byte(BYTE_W'($urandom_range(0, 255)));
			else
				add_byte(CH_DOLLAR);
			n = add_length(5);
			if (n >= 0) begin
				add_random_bytes(n);
				add_crlf();
			end
		end
		if ($urandom_range(0, 9) == 0)
			add_random_bytes($urandom_range(1, 4));
	endfunction

	function automatic void build_unknown_reply();
		logic [BYTE_W-1:0] c;
		c = BYTE_W'($urandom_range(0, 255));
		while (c == CH_PLUS || c == CH_MINUS || c == CH_COLON || c == CH_DOLLAR
			|| c == CH_STAR)
			c = BYTE_W'($urandom_range(0, 255));
		add_byte(c);
		add_random_bytes($urandom_range(0, 4));
	endfunction

	task automatic send_reply();
		for (int i = 0; i < reply_text.size(); i++)
			send_byte(reply_text[i], i == reply_text.size() - 1);
		reply_text.delete();
	endtask

	task automatic test_line_replies();
		add_text("+OK");
		add_crlf();
		send_reply();
		add_byte(CH_MINUS);
		add_crlf();
		send_reply();
		// value cut short on the type byte
		add_byte(CH_COLON);
		send_reply();
	endtask

	task automatic test_bulk_replies();
		add_text("$-1");
		add_crlf();
		send_reply();
		// data byte, value end and reply end from one transaction
		add_text("$1");
		add_crlf();
		add_byte(8'h00);
		send_reply();
	endtask

	task automatic test_list_replies();
		add_text("*1");
		add_crlf();
		add_text("$-1");
		add_crlf();
		send_reply();
	endtask

	task automatic test_unknown_reply();
		add_byte(8'hFF);
		send_reply();
	endtask

	task automatic test_result_backpressure();
		gap_max = 0;
		sink_mode = SINK_FREE;
		hold_wanted++;
		add_text("$40");
		add_crlf();
		add_random_bytes(40);
		add_crlf();
		send_reply();
		hold_wanted++;
		add_text("*4");
		add_crlf();
		repeat (4) begin
			add_text("$-1");
			add_crlf();
		end
		send_reply();
	endtask

	task automatic test_random_replies();
		int start;
		int r;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: gap_max = 0;
				1: gap_max = 2;
				2: gap_max = 5;
				default: gap_max = 12;
			endcase
			sink_mode    = sink_mode_t'($urandom_range(0, 2));
			sink_pattern = 8'($urandom_range(0, 255)) | 8'h01;
			r = $urandom_range(0, 99);
			if (r < 22)
				build_line_reply();
			else if (r < 50)
				build_bulk_reply();
			else if (r < 80)
				build_list_reply();
			else if (r < 88)
				build_unknown_reply();
			else
				add_random_bytes($urandom_range(1, 10));
			// truncated replies end inside any phase
			if ($urandom_range(0, 7) == 0) begin
				r = $urandom_range(1, reply_text.size());
				while (reply_text.size() > r)
					void'(reply_text.pop_back());
			end
			send_reply();
		end
	endtask

	// long hold-off of the result port, counted here
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_wanted) begin
			hold_served <= hold_wanted;
			hold_left   <= HOLD_CYCLES;
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			result.ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_FREE: result.ready <= 1'b1;
				SINK_PATTERN: result.ready <= sink_pattern[cycle_count % 8];
				default: result.ready <= ($urandom_range(0, 99) < 40);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (pending_events.size() == 0) begin
				report_mismatch("result transaction with no event predicted");
			end else begin
				want = pending_events.pop_front();
				if (result.reply_kind !== want.kind)
					report_mismatch($sformatf("reply_kind %0d, predicted %0d",
						result.reply_kind, want.kind));
				if (result.event_kind !== want.ev)
					report_mismatch($sformatf("event_kind %0d, predicted %0d",
						result.event_kind, want.ev));
				if (result.value_byte !== want.data)
					report_mismatch($sformatf("value_byte %h, predicted %h",
						result.value_byte, want.data));
				if (result.element_number !== want.elem)
					report_mismatch($sformatf("element_number %0d, predicted %0d",
						result.element_number, want.elem));
				if (result.run_last !== want.last)
					report_mismatch($sformatf("run_last %b, predicted %b",
						result.run_last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		reply.valid      = 1'b0;
		reply.rx_byte    = '0;
		reply.final_byte = 1'b0;
		result.ready     = 1'b0;
		clear_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_line_replies();
		test_bulk_replies();
		test_list_replies();
		test_unknown_reply();
		test_result_backpressure();
		test_random_replies();

		reply.valid <= 1'b0;
		sink_mode = SINK_FREE;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
